### hdl/motor_command_frame_aggregator_core_assert.svh
// assertion macros shared by the checker
`ifndef MOTOR_COMMAND_FRAME_AGGREGATOR_CORE_ASSERT_SVH
`define MOTOR_COMMAND_FRAME_AGGREGATOR_CORE_ASSERT_SVH

// same-cycle implication
`define MCFA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define MCFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### hdl/mcfa_pkg.sv
`default_nettype none
package mcfa_pkg;
	localparam int BUS_COUNT       = 2;
	localparam int GROUP_COUNT     = 3;
	localparam int SLOTS_PER_GROUP = 4;
	localparam int GROUP_TOTAL     = BUS_COUNT * GROUP_COUNT;
	localparam int SLOT_TOTAL      = GROUP_TOTAL * SLOTS_PER_GROUP;

	localparam int BUS_W     = 1;
	localparam int GROUP_W   = 2;
	localparam int SLOT_W    = 2;
	localparam int GI_W      = (GROUP_TOTAL > 1) ? $clog2(GROUP_TOTAL) : 1;
	localparam int SIDX_W    = (SLOT_TOTAL > 1) ? $clog2(SLOT_TOTAL) : 1;
	localparam int FRAC_W    = 16;
	localparam int VAL_W     = 16;
	localparam int PAYLOAD_W = 64;
	localparam int PRESENT_W = 24;
	localparam int MODEL_W   = 48;
	localparam int CFG_W     = 48;
	localparam int CFG_IDX_W = 1;
	localparam int FS_W      = 15;
	localparam int MAG_W     = FRAC_W + 1;
	localparam int PROD_W    = MAG_W + FS_W;
	localparam int FRAC_SH   = 15;

	localparam logic [CFG_IDX_W-1:0] REG_PRESENT_MAP = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODEL_MAP   = 1'd1;

	localparam logic [1:0] MODEL_NONE   = 2'd0;
	localparam logic [1:0] MODEL_SMALL  = 2'd1;
	localparam logic [1:0] MODEL_MID    = 2'd2;
	localparam logic [1:0] MODEL_GIMBAL = 2'd3;

	localparam logic [FS_W-1:0] FS_SMALL  = 15'd10000;
	localparam logic [FS_W-1:0] FS_MID    = 15'd16384;
	localparam logic [FS_W-1:0] FS_GIMBAL = 15'd30000;

	typedef logic [SLOTS_PER_GROUP-1:0] flags_t;

	typedef struct packed {
		flags_t                 flags;
		logic [PAYLOAD_W-1:0]   payload;
	} entry_t;

	function automatic logic [FS_W-1:0] full_scale_of(input logic [1:0] code);
		logic [FS_W-1:0] fs;
		unique case (code)
			MODEL_SMALL:  fs = FS_SMALL;
			MODEL_MID:    fs = FS_MID;
			MODEL_GIMBAL: fs = FS_GIMBAL;
			default:      fs = '0;
		endcase
		return fs;
	endfunction
endpackage
`default_nettype wire

### hdl/mcfa_store.sv
`default_nettype none
module mcfa_store (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            rd_en,
	input  wire logic [mcfa_pkg::GI_W-1:0]       rd_addr,
	output mcfa_pkg::entry_t                     rd_data,
	input  wire logic                            wr_en,
	input  wire logic [mcfa_pkg::GI_W-1:0]       wr_addr,
	input  mcfa_pkg::entry_t                     wr_data
);
	mcfa_pkg::entry_t                       mem [mcfa_pkg::GROUP_TOTAL];
	logic [mcfa_pkg::GROUP_TOTAL-1:0]       vld_q;
	mcfa_pkg::entry_t                       rd_q;
	logic                                   rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// an entry never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;
endmodule
`default_nettype wire

### hdl/mcfa_scale.sv
`default_nettype none
module mcfa_scale (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic signed [mcfa_pkg::FRAC_W-1:0] fraction,
	input  wire logic [1:0]                        code,
	output logic [mcfa_pkg::VAL_W-1:0]             value
);
	logic                              neg;
	logic [mcfa_pkg::MAG_W-1:0]        mag;
	logic [mcfa_pkg::PROD_W-1:0]       prod;
	logic [mcfa_pkg::VAL_W-1:0]        mag_q;
	logic                              neg_q;

	// sign and magnitude, scaled magnitude truncates toward zero
	always_comb begin
		neg  = fraction[mcfa_pkg::FRAC_W-1];
		mag  = neg ? {1'b0, mcfa_pkg::FRAC_W'(0) - fraction}
		           : {1'b0, fraction};
		prod = mcfa_pkg::PROD_W'(mag) * mcfa_pkg::PROD_W'(mcfa_pkg::full_scale_of(code));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_q <= prod[mcfa_pkg::FRAC_SH +: mcfa_pkg::VAL_W];
			neg_q <= neg;
		end
	end

	assign value = neg_q ? (mcfa_pkg::VAL_W'(0) - mag_q) : mag_q;
endmodule
`default_nettype wire

### hdl/motor_command_frame_aggregator_core.sv
// Motor command frame aggregator. Each input word is one motor command (bus,
// group and slot in tuser, Q1.15 fraction in tdata). The fraction is scaled by
// the slot's model full scale, truncated toward zero and stored big-endian in
// the group's 8-byte buffer, which lives in a small synchronous memory with
// per-entry updated flags. When all present slots of a group are flagged the
// frame goes out on the master side and the flags clear. A command passes
// through accept and memory read, scale multiply, and merge and write-back,
// and no new word is accepted until it is through; a frame that finds the
// output register still occupied holds the write-back until the register
// frees. Commands to a slot with no model or a group out of range are
// dropped and return the input to ready without a write.
`default_nettype none
module motor_command_frame_aggregator_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // command_fraction
	input  wire logic [4:0]  s_tuser,   // bus_select, group_select, slot_select
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // frame_payload
	output logic [2:0]       m_tuser,   // frame_bus, frame_group
	input  wire logic        cfg_we,
	input  wire logic [mcfa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [mcfa_pkg::CFG_W-1:0]     cfg_data
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	logic [1:0]                              state_q;
	logic [mcfa_pkg::PRESENT_W-1:0]          present_map_q;
	logic [mcfa_pkg::MODEL_W-1:0]            model_map_q;

	logic [mcfa_pkg::BUS_W-1:0]              bus_s1;
	logic [mcfa_pkg::GROUP_W-1:0]            grp_s1;
	logic [mcfa_pkg::SLOT_W-1:0]             slot_s1;
	logic signed [mcfa_pkg::FRAC_W-1:0]      frac_s1;
	logic                                    ok_s1;

	logic [mcfa_pkg::BUS_W-1:0]              in_bus;
	logic [mcfa_pkg::GROUP_W-1:0]            in_grp;
	logic [mcfa_pkg::SLOT_W-1:0]             in_slot;
	logic                                    in_ok;
	logic [mcfa_pkg::GI_W-1:0]               in_gi;
	logic                                    accept;

	logic [mcfa_pkg::GI_W-1:0]               gi_s1;
	logic [mcfa_pkg::SIDX_W-1:0]             sidx_s1;
	logic [1:0]                              code_s1;
	logic                                    hit_s1;
	logic [mcfa_pkg::VAL_W-1:0]              value;
	mcfa_pkg::entry_t                        rd_entry;
	mcfa_pkg::entry_t                        new_entry;
	mcfa_pkg::flags_t                        present;
	logic                                    done;
	logic                                    out_free;
	logic                                    stall;
	logic                                    wr_en;

	logic                                    m_tvalid_q;
	logic [mcfa_pkg::PAYLOAD_W-1:0]          out_payload_q;
	logic [mcfa_pkg::BUS_W-1:0]              out_bus_q;
	logic [mcfa_pkg::GROUP_W-1:0]            out_grp_q;

	assign in_bus  = s_tuser[0 +: mcfa_pkg::BUS_W];
	assign in_grp  = s_tuser[mcfa_pkg::BUS_W +: mcfa_pkg::GROUP_W];
	assign in_slot = s_tuser[mcfa_pkg::BUS_W + mcfa_pkg::GROUP_W +: mcfa_pkg::SLOT_W];
	assign in_ok   = (32'(in_bus) < 32'(mcfa_pkg::BUS_COUNT))
	               && (32'(in_grp) < 32'(mcfa_pkg::GROUP_COUNT))
	               && (32'(in_slot) < 32'(mcfa_pkg::SLOTS_PER_GROUP));
	assign in_gi   = mcfa_pkg::GI_W'(in_bus) * mcfa_pkg::GI_W'(mcfa_pkg::GROUP_COUNT)
	               + mcfa_pkg::GI_W'(in_grp);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	assign gi_s1   = mcfa_pkg::GI_W'(bus_s1) * mcfa_pkg::GI_W'(mcfa_pkg::GROUP_COUNT)
	               + mcfa_pkg::GI_W'(grp_s1);
	assign sidx_s1 = mcfa_pkg::SIDX_W'(gi_s1) * mcfa_pkg::SIDX_W'(mcfa_pkg::SLOTS_PER_GROUP)
	               + mcfa_pkg::SIDX_W'(slot_s1);
	assign code_s1 = model_map_q[2 * sidx_s1 +: 2];
	assign hit_s1  = ok_s1 && (code_s1 != mcfa_pkg::MODEL_NONE);
	assign present = present_map_q[mcfa_pkg::SLOTS_PER_GROUP * gi_s1 +: mcfa_pkg::SLOTS_PER_GROUP];

	mcfa_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && in_ok),
		.rd_addr (in_gi),
		.rd_data (rd_entry),
		.wr_en   (wr_en),
		.wr_addr (gi_s1),
		.wr_data (new_entry)
	);

	mcfa_scale u_scale (
		.clk      (clk),
		.en       (state_q == ST_READ),
		.fraction (frac_s1),
		.code     (code_s1),
		.value    (value)
	);

	// merge the scaled command into the slot, high byte first
	always_comb begin
		mcfa_pkg::flags_t flags_set;
		new_entry = rd_entry;
		flags_set = rd_entry.flags;
		for (int s = 0; s < mcfa_pkg::SLOTS_PER_GROUP; s++) begin
			if (slot_s1 == mcfa_pkg::SLOT_W'(s)) begin
				new_entry.payload[mcfa_pkg::PAYLOAD_W - mcfa_pkg::VAL_W * (s + 1) +:
				                  mcfa_pkg::VAL_W] = value;
				flags_set[s] = 1'b1;
			end
		end
		done            = &(flags_set | ~present);
		new_entry.flags = done ? '0 : flags_set;
	end

	assign out_free = !m_tvalid_q || m_tready;
	assign stall    = done && !out_free;
	assign wr_en    = (state_q == ST_UPD) && hit_s1 && !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			present_map_q <= '0;
			model_map_q   <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					mcfa_pkg::REG_PRESENT_MAP: present_map_q <= cfg_data[mcfa_pkg::PRESENT_W-1:0];
					mcfa_pkg::REG_MODEL_MAP:   model_map_q   <= cfg_data[mcfa_pkg::MODEL_W-1:0];
					default: ;
				endcase
			end
			if (m_tvalid_q && m_tready && !(wr_en && done)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= hit_s1 ? ST_UPD : ST_IDLE;
				end
				ST_UPD: begin
					if (!stall) begin
						state_q <= ST_IDLE;
						if (done) begin
							m_tvalid_q <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bus_s1  <= in_bus;
			grp_s1  <= in_grp;
			slot_s1 <= in_slot;
			frac_s1 <= s_tdata;
			ok_s1   <= in_ok;
		end
		if (wr_en && done) begin
			out_payload_q <= new_entry.payload;
			out_bus_q     <= bus_s1;
			out_grp_q     <= grp_s1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_payload_q;
	assign m_tuser  = {out_grp_q, out_bus_q};
endmodule
`default_nettype wire

### hdl/mcfa_checker.sv
`default_nettype none
`include "motor_command_frame_aggregator_core_assert.svh"
module mcfa_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [2:0]  m_tuser
);
	`MCFA_ASSERT_NEXT(a_out_holds, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`MCFA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`MCFA_ASSERT_NEXT(a_no_early_frame, clk, arst_n, s_tvalid && s_tready, !$rose(m_tvalid))
	`MCFA_ASSERT_NOW(a_frame_group_valid, clk, arst_n, m_tvalid, m_tuser[2:1] != 2'd3)
endmodule

bind motor_command_frame_aggregator_core mcfa_checker u_mcfa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tuser  (m_tuser)
);
`default_nettype wire
